// ===== hdl/sksr_pkg.sv =====
// ----------------------------------------------------------------------------
// sksr_pkg: shared definitions for the string key slot registry
// Action and status codes, field widths, default sizes and the scan control
// bundle passed from the sequencer to the compare unit.
// ----------------------------------------------------------------------------
package sksr_pkg;

  // default sizes
  localparam int SLOTS_DEF   = 16;
  localparam int KEY_MAX_DEF = 108;

  // field widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int POS_W    = 8;

  localparam logic [POS_W-1:0] POS_SAT = 8'hFF;

  // actions
  localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // sequencer to compare unit
  typedef struct packed {
    logic clr;   // new transaction, clear the running search
    logic cmp;   // read data for one slot is present this cycle
  } scan_ctl_t;

endpackage

// ===== hdl/sksr_ram.sv =====
// ----------------------------------------------------------------------------
// sksr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sksr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sksr_scan.sv =====
// ----------------------------------------------------------------------------
// sksr_scan: shared slot compare unit
// Takes one slot per cycle: key byte compare, length checks, and running
// search for the lowest matching slot and the lowest free slot.
// ----------------------------------------------------------------------------
module sksr_scan #(
  parameter int SW = 4,
  parameter int LW = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sksr_pkg::scan_ctl_t               ctl,
  input  logic [SW-1:0]                     slot,
  input  logic                              used,
  input  logic                              mism,
  input  logic [LW-1:0]                     len,
  input  logic [sksr_pkg::BYTE_W-1:0]       key_data,
  input  logic [sksr_pkg::HANDLE_W-1:0]     handle,
  input  logic [sksr_pkg::BYTE_W-1:0]       key_byte,
  input  logic [sksr_pkg::POS_W-1:0]        pos,
  input  logic [sksr_pkg::POS_W-1:0]        pos_new,
  output logic                              mism_new,
  output logic                              found_vld,
  output logic [SW-1:0]                     found_slot,
  output logic [sksr_pkg::HANDLE_W-1:0]     found_handle,
  output logic                              free_vld,
  output logic [SW-1:0]                     free_slot
);

  logic [sksr_pkg::POS_W-1:0]    len_ext;
  logic                          diff;
  logic                          hit;

  logic                          found_vld_r, found_vld_nxt;
  logic [SW-1:0]                 found_slot_r, found_slot_nxt;
  logic [sksr_pkg::HANDLE_W-1:0] found_handle_r, found_handle_nxt;
  logic                          free_vld_r, free_vld_nxt;
  logic [SW-1:0]                 free_slot_r, free_slot_nxt;

  assign len_ext  = sksr_pkg::POS_W'(len);
  // zero byte adds nothing, so it never marks a slot
  assign diff     = (key_byte != '0) && ((pos >= len_ext) || (key_data != key_byte));
  assign mism_new = mism | diff;
  assign hit      = used && !mism_new && (len_ext == pos_new) && (pos_new != '0);

  always_comb begin
    found_vld_nxt    = found_vld_r;
    found_slot_nxt   = found_slot_r;
    found_handle_nxt = found_handle_r;
    free_vld_nxt     = free_vld_r;
    free_slot_nxt    = free_slot_r;
    if (ctl.clr) begin
      found_vld_nxt = 1'b0;
      free_vld_nxt  = 1'b0;
    end else if (ctl.cmp) begin
      if (hit && !found_vld_r) begin
        found_vld_nxt    = 1'b1;
        found_slot_nxt   = slot;
        found_handle_nxt = handle;
      end
      if (!used && !free_vld_r) begin
        free_vld_nxt  = 1'b1;
        free_slot_nxt = slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      found_vld_r <= found_vld_nxt;
      free_vld_r  <= free_vld_nxt;
    end
    found_slot_r   <= found_slot_nxt;
    found_handle_r <= found_handle_nxt;
    free_slot_r    <= free_slot_nxt;
  end

  assign found_vld    = found_vld_r;
  assign found_slot   = found_slot_r;
  assign found_handle = found_handle_r;
  assign free_vld     = free_vld_r;
  assign free_slot    = free_slot_r;

endmodule

// ===== hdl/string_key_slot_registry.sv =====
// ----------------------------------------------------------------------------
// string_key_slot_registry: fixed slot table of string keys and handles
// Register, look up and unregister keys streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one key byte per transaction
//   with in_action, in_key_last and in_handle_in. Action and handle count on
//   the transaction that has in_key_last set; a zero byte adds nothing.
//   Each key_last transaction gives one result on the out_ channel
//   (status, slot_index, handle_out); other transactions give none.
//   Sequence: each input transaction has an accept cycle, a scan in which
//   the single compare unit walks the slots one per cycle behind the
//   registered RAM read, and a finish cycle that commits table updates.
//   in_ready is high only when idle.
//   A result appears in out_ registers at the end of the finish cycle.
//   Stall: a held result does not block non-final bytes; a final byte waits
//   in the finish cycle until the output register is free.
//   Reset: rst_n (synchronous, active low) empties the table; key storage
//   needs no clearing since only used slots can report a match.
// ----------------------------------------------------------------------------
module string_key_slot_registry #(
  parameter int SLOTS   = sksr_pkg::SLOTS_DEF,
  parameter int KEY_MAX = sksr_pkg::KEY_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sksr_pkg::ACTION_W-1:0]     in_action,
  input  logic [sksr_pkg::BYTE_W-1:0]       in_key_byte,
  input  logic                              in_key_last,
  input  logic [sksr_pkg::HANDLE_W-1:0]     in_handle_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sksr_pkg::STATUS_W-1:0]     out_status,
  output logic [sksr_pkg::IDX_W-1:0]        out_slot_index,
  output logic [sksr_pkg::HANDLE_W-1:0]     out_handle_out
);

  // slot index, slot counter, key position and stored length widths
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = $clog2(KEY_MAX);
  localparam int LW = $clog2(KEY_MAX);
  localparam int MW = LW + sksr_pkg::HANDLE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [sksr_pkg::POS_W-1:0] POS_LIMIT = sksr_pkg::POS_W'(KEY_MAX - 1);

  logic [1:0]                        state_r, state_nxt;
  logic [sksr_pkg::ACTION_W-1:0]     action_r, action_nxt;
  logic [sksr_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic                              last_r, last_nxt;
  logic [sksr_pkg::HANDLE_W-1:0]     hin_r, hin_nxt;
  logic [sksr_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [SLOTS-1:0]                  used_r, used_nxt;
  logic [SLOTS-1:0]                  mism_r, mism_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [SW-1:0]                     cmp_slot_r, cmp_slot_nxt;
  logic                              cmp_vld_r, cmp_vld_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [sksr_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [sksr_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [sksr_pkg::HANDLE_W-1:0]     hout_r, hout_nxt;

  logic                              in_fire;
  logic                              issue;
  logic                              fin_go;
  logic [sksr_pkg::POS_W-1:0]        pos_new;
  logic [LW-1:0]                     len_trunc;

  sksr_pkg::scan_ctl_t               scan_ctl;
  logic                              mism_new;
  logic                              found_vld;
  logic [SW-1:0]                     found_slot;
  logic [sksr_pkg::HANDLE_W-1:0]     found_handle;
  logic                              free_vld;
  logic [SW-1:0]                     free_slot;

  logic                              key_we;
  logic [SW+PW-1:0]                  key_wr_addr;
  logic [SW+PW-1:0]                  key_rd_addr;
  logic [sksr_pkg::BYTE_W-1:0]       key_rd_data;
  logic                              meta_we;
  logic [MW-1:0]                     meta_wr_data;
  logic [MW-1:0]                     meta_rd_data;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state_r == S_SCAN) && (cnt_r < CW'(SLOTS));
  // final bytes need the output register; others finish at once
  assign fin_go   = (state_r == S_FIN) && (!last_r || !out_valid_r || out_ready);

  assign pos_new   = ((byte_r != '0) && (pos_r != sksr_pkg::POS_SAT)) ?
                     pos_r + sksr_pkg::POS_W'(1) : pos_r;
  assign len_trunc = (pos_new < POS_LIMIT) ? LW'(pos_new) : LW'(KEY_MAX - 1);

  // key storage: row per slot, column per byte position
  assign key_rd_addr  = {cnt_r[SW-1:0], pos_r[PW-1:0]};
  assign key_wr_addr  = {free_slot, pos_r[PW-1:0]};
  assign key_we       = fin_go && (byte_r != '0) && (pos_r < POS_LIMIT) && free_vld;
  assign meta_wr_data = {len_trunc, hin_r};

  assign scan_ctl.clr = in_fire;
  assign scan_ctl.cmp = cmp_vld_r;

  sksr_ram #(
    .WIDTH (sksr_pkg::BYTE_W),
    .DEPTH (1 << (SW + PW))
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_wr_addr),
    .wr_data (byte_r),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  // per-slot length and handle, written on a successful register
  sksr_ram #(
    .WIDTH (MW),
    .DEPTH (1 << SW)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (free_slot),
    .wr_data (meta_wr_data),
    .rd_addr (cnt_r[SW-1:0]),
    .rd_data (meta_rd_data)
  );

  sksr_scan #(
    .SW (SW),
    .LW (LW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (scan_ctl),
    .slot         (cmp_slot_r),
    .used         (used_r[cmp_slot_r]),
    .mism         (mism_r[cmp_slot_r]),
    .len          (meta_rd_data[MW-1:sksr_pkg::HANDLE_W]),
    .key_data     (key_rd_data),
    .handle       (meta_rd_data[sksr_pkg::HANDLE_W-1:0]),
    .key_byte     (byte_r),
    .pos          (pos_r),
    .pos_new      (pos_new),
    .mism_new     (mism_new),
    .found_vld    (found_vld),
    .found_slot   (found_slot),
    .found_handle (found_handle),
    .free_vld     (free_vld),
    .free_slot    (free_slot)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    hin_nxt       = hin_r;
    pos_nxt       = pos_r;
    used_nxt      = used_r;
    mism_nxt      = mism_r;
    cnt_nxt       = cnt_r;
    cmp_slot_nxt  = cmp_slot_r;
    cmp_vld_nxt   = issue;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    hout_nxt      = hout_r;
    meta_we       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (issue) begin
      cnt_nxt      = cnt_r + CW'(1);
      cmp_slot_nxt = cnt_r[SW-1:0];
    end

    if (cmp_vld_r) begin
      mism_nxt[cmp_slot_r] = mism_new;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          action_nxt = in_action;
          byte_nxt   = in_key_byte;
          last_nxt   = in_key_last;
          hin_nxt    = in_handle_in;
          cnt_nxt    = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && (cmp_slot_r == SW'(SLOTS - 1))) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (!last_r) begin
            pos_nxt = pos_new;
          end else begin
            pos_nxt       = '0;
            mism_nxt      = '0;
            out_valid_nxt = 1'b1;
            idx_nxt       = '0;
            hout_nxt      = '0;
            case (action_r)
              sksr_pkg::ACT_REGISTER: begin
                if ((pos_new == '0) || (hin_r == '0)) begin
                  status_nxt = sksr_pkg::ST_INVALID;
                end else if (found_vld) begin
                  status_nxt = sksr_pkg::ST_EXISTS;
                  idx_nxt    = sksr_pkg::IDX_W'(found_slot);
                end else if (!free_vld) begin
                  status_nxt = sksr_pkg::ST_FULL;
                end else begin
                  status_nxt          = sksr_pkg::ST_OK;
                  idx_nxt             = sksr_pkg::IDX_W'(free_slot);
                  used_nxt[free_slot] = 1'b1;
                  meta_we             = 1'b1;
                end
              end
              sksr_pkg::ACT_LOOKUP: begin
                if (found_vld) begin
                  status_nxt = sksr_pkg::ST_OK;
                  idx_nxt    = sksr_pkg::IDX_W'(found_slot);
                  hout_nxt   = found_handle;
                end else begin
                  status_nxt = sksr_pkg::ST_NOT_FOUND;
                end
              end
              sksr_pkg::ACT_UNREGISTER: begin
                if (found_vld) begin
                  status_nxt           = sksr_pkg::ST_OK;
                  idx_nxt              = sksr_pkg::IDX_W'(found_slot);
                  used_nxt[found_slot] = 1'b0;
                end else begin
                  status_nxt = sksr_pkg::ST_NOT_FOUND;
                end
              end
              default: begin
                status_nxt = sksr_pkg::ST_INVALID;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      used_r      <= '0;
      mism_r      <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      used_r      <= used_nxt;
      mism_r      <= mism_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r   <= action_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    hin_r      <= hin_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    hout_r     <= hout_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot_index = idx_r;
  assign out_handle_out = hout_r;

`ifndef ASSERT_OFF
  // a result only comes out of the finish cycle
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish cycle");

  // the matching slot reported by the scan is in use
  a_found_used: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && found_vld) |-> used_r[found_slot])
    else $error("matched slot is not in use");

  // the free slot reported by the scan is not in use
  a_free_unused: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && free_vld) |-> !used_r[free_slot])
    else $error("free slot is in use");

  // slots are only marked once a key byte has been taken
  a_mism_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (pos_r == '0)) |-> (mism_r == '0))
    else $error("mismatch marks left at start of key");
`endif

endmodule
